>>> hdl/tanh_activation_unit_top_defines.svh
// assertion macros shared by the tanh unit checker
// no dependencies; expects aclk and aresetn in the scope of each use
`ifndef TANH_ACTIVATION_UNIT_TOP_DEFINES_SVH
`define TANH_ACTIVATION_UNIT_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TAU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tanh unit: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tanh unit: next-cycle check failed");

`endif

>>> hdl/tau_pkg.sv
// shared types, constants and the tanh lookup table for the tanh activation unit
// no dependencies
package tau_pkg;

    // fixed point format and table geometry
    localparam int FRAC_BITS     = 12;
    localparam int TABLE_STEPS   = 256;
    localparam int TABLE_ENTRIES = TABLE_STEPS + 1;
    localparam int ONE           = 1 << FRAC_BITS;
    localparam int SPAN          = 8 << FRAC_BITS;
    localparam int STEP          = SPAN / TABLE_STEPS;
    localparam int STEP_BITS     = $clog2(STEP);
    localparam int IDX_BITS      = $clog2(TABLE_STEPS);
    localparam int MAG_BITS      = $clog2(TABLE_STEPS * STEP);
    localparam int CLIP_LIM      = TABLE_STEPS * STEP - 1;
    localparam int ENTRY_BITS    = FRAC_BITS + 1;
    localparam real ONE_INV      = 1.0 / real'(ONE);

    // word field widths
    localparam int DATA_BITS = 16;

    // backward path widths
    localparam int SQ_BITS   = 2 * DATA_BITS - 1;
    localparam int Y2_BITS   = SQ_BITS - FRAC_BITS + 1;
    localparam int G_BITS    = Y2_BITS + 1;
    localparam int PROD_BITS = G_BITS + DATA_BITS;
    localparam int RES_BITS  = PROD_BITS - FRAC_BITS;

    // request codes
    typedef enum logic {
        REQ_FORWARD  = 1'b0,
        REQ_BACKWARD = 1'b1
    } tau_req_t;

    typedef struct packed {
        tau_req_t                     req_type;
        logic signed [DATA_BITS-1:0]  operand;
        logic signed [DATA_BITS-1:0]  error_value;
    } tau_in_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0]  result_value;
        logic                         saturated;
    } tau_out_t;

    typedef logic [ENTRY_BITS-1:0] tau_table_t [TABLE_ENTRIES];

    // round(tanh(k * STEP / 2^FRAC_BITS) * 2^FRAC_BITS), built at elaboration
    function automatic tau_table_t build_tanh_table();
        tau_table_t tbl;
        real        x_val;
        real        t_val;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            x_val  = real'(k * STEP) * ONE_INV;
            t_val  = $tanh(x_val) * real'(ONE);
            tbl[k] = ENTRY_BITS'($rtoi(t_val + 0.5));
        end
        return tbl;
    endfunction

    localparam tau_table_t TANH_TABLE = build_tanh_table();

endpackage

>>> hdl/tanh_activation_unit_top.sv
// Element-wise tanh activation unit in signed Q3.12: a forward word returns
// tanh(operand) from a 257-point table with linear interpolation, a backward
// word returns (1 - y*y) * error_value rounded and saturated to 16 bits with a
// flag. Depends on tau_pkg.
//
// The unit is a four-stage pipeline with valid bits in every stage and takes
// one word per clock cycle while the output is not stalled. The depth is set
// by the square of the operand in the first stage, the table read in the
// second, the interpolation and gradient multipliers in the third and
// rounding plus saturation in the fourth. A stalled output holds its word
// while bubbles in earlier stages still fill, so s_ready drops only when all
// four stages hold data. There is no state between words and no set-up
// after reset.
module tanh_activation_unit_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tau_pkg::tau_in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tau_pkg::tau_out_t m_data
);
    import tau_pkg::*;

    // stage advance chain, last stage first
    logic adv1, adv2, adv3, adv4;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;

    assign adv4    = !m_valid_reg || m_ready;
    assign adv3    = !s3_valid_reg || adv4;
    assign adv2    = !s2_valid_reg || adv3;
    assign adv1    = !s1_valid_reg || adv2;
    assign s_ready = adv1;

    // ---------------- stage 1: magnitude, clip, square ----------------
    logic [DATA_BITS:0]                abs_x;
    logic [MAG_BITS-1:0]               clip_a;
    logic signed [2*DATA_BITS-1:0]     sq_full;
    logic [IDX_BITS-1:0]               s1_idx_next;
    logic [STEP_BITS-1:0]              s1_frac_next;
    logic [SQ_BITS-1:0]                s1_ysq_next;

    logic [IDX_BITS-1:0]               s1_idx_reg;
    logic [STEP_BITS-1:0]              s1_frac_reg;
    logic [SQ_BITS-1:0]                s1_ysq_reg;
    logic                              s1_neg_reg;
    tau_req_t                          s1_req_reg;
    logic signed [DATA_BITS-1:0]       s1_err_reg;

    always_comb begin
        abs_x = s_data.operand[DATA_BITS-1]
              ? (DATA_BITS+1)'(~{1'b1, s_data.operand} + 1'b1)
              : {1'b0, s_data.operand};
        clip_a = (int'(abs_x) > CLIP_LIM) ? MAG_BITS'(CLIP_LIM) : MAG_BITS'(abs_x);
        s1_idx_next  = IDX_BITS'(clip_a >> STEP_BITS);
        s1_frac_next = clip_a[STEP_BITS-1:0];
        sq_full      = s_data.operand * s_data.operand;
        s1_ysq_next  = sq_full[SQ_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s1_idx_reg  <= s1_idx_next;
            s1_frac_reg <= s1_frac_next;
            s1_ysq_reg  <= s1_ysq_next;
            s1_neg_reg  <= s_data.operand[DATA_BITS-1];
            s1_req_reg  <= s_data.req_type;
            s1_err_reg  <= s_data.error_value;
        end
    end

    // ---------------- stage 2: table read, 1 - y*y ----------------
    logic [IDX_BITS:0]                 idx_hi;
    logic [ENTRY_BITS-1:0]             tbl_lo;
    logic [ENTRY_BITS-1:0]             tbl_hi;
    logic [SQ_BITS:0]                  ysq_rnd;
    logic [Y2_BITS-1:0]                y2;
    logic [ENTRY_BITS-1:0]             s2_diff_next;
    logic signed [G_BITS-1:0]          s2_g_next;

    logic [ENTRY_BITS-1:0]             s2_lo_reg;
    logic [ENTRY_BITS-1:0]             s2_diff_reg;
    logic [STEP_BITS-1:0]              s2_frac_reg;
    logic signed [G_BITS-1:0]          s2_g_reg;
    logic                              s2_neg_reg;
    tau_req_t                          s2_req_reg;
    logic signed [DATA_BITS-1:0]       s2_err_reg;

    always_comb begin
        idx_hi       = (IDX_BITS+1)'(s1_idx_reg) + 1'b1;
        tbl_lo       = TANH_TABLE[{1'b0, s1_idx_reg}];
        tbl_hi       = TANH_TABLE[idx_hi];
        s2_diff_next = (tbl_hi >= tbl_lo) ? ENTRY_BITS'(tbl_hi - tbl_lo) : '0;
        ysq_rnd      = (SQ_BITS+1)'(s1_ysq_reg) + (SQ_BITS+1)'(ONE >> 1);
        y2           = Y2_BITS'(ysq_rnd >> FRAC_BITS);
        s2_g_next    = $signed(G_BITS'(ONE)) - $signed({1'b0, y2});
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            s2_lo_reg   <= tbl_lo;
            s2_diff_reg <= s2_diff_next;
            s2_frac_reg <= s1_frac_reg;
            s2_g_reg    <= s2_g_next;
            s2_neg_reg  <= s1_neg_reg;
            s2_req_reg  <= s1_req_reg;
            s2_err_reg  <= s1_err_reg;
        end
    end

    // ---------------- stage 3: interpolation and gradient products ----------------
    logic [ENTRY_BITS+STEP_BITS-1:0]   s3_fprod_next;
    logic signed [PROD_BITS-1:0]       s3_bprod_next;

    logic [ENTRY_BITS+STEP_BITS-1:0]   s3_fprod_reg;
    logic signed [PROD_BITS-1:0]       s3_bprod_reg;
    logic [ENTRY_BITS-1:0]             s3_lo_reg;
    logic                              s3_neg_reg;
    tau_req_t                          s3_req_reg;

    always_comb begin
        s3_fprod_next = (ENTRY_BITS+STEP_BITS)'(s2_diff_reg) * (ENTRY_BITS+STEP_BITS)'(s2_frac_reg);
        s3_bprod_next = PROD_BITS'(s2_g_reg) * PROD_BITS'(s2_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            s3_fprod_reg <= s3_fprod_next;
            s3_bprod_reg <= s3_bprod_next;
            s3_lo_reg    <= s2_lo_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_req_reg   <= s2_req_reg;
        end
    end

    // ---------------- stage 4: round, sign, saturate ----------------
    logic [ENTRY_BITS+STEP_BITS:0]     fprod_rnd;
    logic [ENTRY_BITS-1:0]             fwd_mag;
    logic [DATA_BITS-1:0]              fwd_res;
    logic signed [PROD_BITS-1:0]       bprod_rnd;
    logic signed [RES_BITS-1:0]        bwd_full;
    logic signed [DATA_BITS-1:0]       bwd_res;
    logic                              bwd_sat;
    tau_out_t                          m_data_next;
    tau_out_t                          m_data_reg;

    always_comb begin
        fprod_rnd = (ENTRY_BITS+STEP_BITS+1)'(s3_fprod_reg)
                  + (ENTRY_BITS+STEP_BITS+1)'(STEP >> 1);
        fwd_mag   = s3_lo_reg + ENTRY_BITS'(fprod_rnd >> STEP_BITS);
        fwd_res   = DATA_BITS'(fwd_mag);
        if (s3_neg_reg) begin
            fwd_res = DATA_BITS'(~fwd_res + 1'b1);
        end

        bprod_rnd = s3_bprod_reg + $signed(PROD_BITS'(ONE >> 1));
        bwd_full  = RES_BITS'(bprod_rnd >>> FRAC_BITS);
        if (bwd_full > $signed(RES_BITS'(32767))) begin
            bwd_res = 16'sh7fff;
            bwd_sat = 1'b1;
        end else if (bwd_full < -$signed(RES_BITS'(32768))) begin
            bwd_res = 16'sh8000;
            bwd_sat = 1'b1;
        end else begin
            bwd_res = DATA_BITS'(bwd_full);
            bwd_sat = 1'b0;
        end

        unique case (s3_req_reg)
            REQ_FORWARD: begin
                m_data_next.result_value = $signed(fwd_res);
                m_data_next.saturated    = 1'b0;
            end
            REQ_BACKWARD: begin
                m_data_next.result_value = bwd_res;
                m_data_next.saturated    = bwd_sat;
            end
            default: begin
                m_data_next.result_value = '0;
                m_data_next.saturated    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            m_data_reg <= m_data_next;
        end
    end

    // valid bits travel with the words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (adv1) begin
                s1_valid_reg <= s_valid;
            end
            if (adv2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (adv4) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/tau_checker.sv
// port-level checks for the tanh activation unit, bound to the top level
// depends on tau_pkg and tanh_activation_unit_top_defines.svh
`include "tanh_activation_unit_top_defines.svh"

module tau_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input tau_pkg::tau_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input tau_pkg::tau_out_t m_data
);
    import tau_pkg::*;

    // a stalled result word holds
    `TAU_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // the flag only comes with a clipped value
    `TAU_ASSERT_SAME(a_sat_extreme, m_valid && m_data.saturated, m_data.result_value == 16'sh7fff || m_data.result_value == 16'sh8000)

    // with the output stage empty the pipe can always take a word
    `TAU_ASSERT_SAME(a_ready_when_drained, !m_valid, s_ready)

endmodule

bind tanh_activation_unit_top tau_checker u_tau_checker (.*);
